@@ hw/rtl/iorb_pkg.sv @@
// ----------------------------------------------------------------------------
// iorb_pkg
// Shared types and constants of the in-order release buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package iorb_pkg;

  localparam int WINDOW_DEPTH = 16;
  localparam int MAX_RESULTS  = 16;

  localparam int POS_W    = 32;
  localparam int STATUS_W = 8;
  localparam int HANDLE_W = 16;
  localparam int COUNT_W  = 32;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_ORDERED_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OK_STATUS    = 1'd1;

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_END     = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_UNORD,
    ST_REJ,
    ST_READ,
    ST_REL
  } state_t;

  typedef struct packed {
    logic in_valid;
    logic finished;
    logic ordered;
    logic win_ok;
    logic out_free;
    logic rel_go;
  } sts_t;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic insert;
    logic emit_unord;
    logic emit_rej;
    logic rd;
    logic emit_rel;
  } ctl_t;

  typedef struct packed {
    logic                is_end;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle;
  } slot_wr_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle;
  } slot_data_t;

endpackage

`default_nettype wire

@@ hw/rtl/iorb_slots.sv @@
// ----------------------------------------------------------------------------
// iorb_slots
// Slot storage: valid and end-marker bits in flops, status and handle in a
// memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module iorb_slots #(
  parameter int DEPTH = iorb_pkg::WINDOW_DEPTH,
  parameter int IW    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [IW-1:0]        wr_idx,
  input  iorb_pkg::slot_wr_t   wr_data,
  input  logic                 clr_en,
  input  logic [IW-1:0]        clr_idx,
  input  logic                 rd_en,
  input  logic [IW-1:0]        rd_idx,
  output iorb_pkg::slot_data_t rd_data,
  output logic [DEPTH-1:0]     slot_valid,
  output logic [DEPTH-1:0]     slot_end
);

  iorb_pkg::slot_data_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      slot_end   <= '0;
    end else begin
      if (wr_en) begin
        slot_valid[wr_idx] <= 1'b1;
        slot_end[wr_idx]   <= wr_data.is_end;
      end
      if (clr_en) begin
        slot_valid[clr_idx] <= 1'b0;
        slot_end[clr_idx]   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= '{status: wr_data.status, handle: wr_data.handle};
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/iorb_ctrl.sv @@
// ----------------------------------------------------------------------------
// iorb_ctrl
// Sequencer: check one item and insert, reject or pass it through, then release held slots one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module iorb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  iorb_pkg::sts_t sts,
  output iorb_pkg::ctl_t ctl
);

  iorb_pkg::state_t state;
  iorb_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iorb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      iorb_pkg::ST_IDLE: begin
        if (sts.in_valid && !sts.finished) state_next = iorb_pkg::ST_CHECK;
      end
      iorb_pkg::ST_CHECK: begin
        if (!sts.ordered)     state_next = iorb_pkg::ST_UNORD;
        else if (!sts.win_ok) state_next = iorb_pkg::ST_REJ;
        else                  state_next = iorb_pkg::ST_READ;
      end
      iorb_pkg::ST_UNORD: begin
        if (sts.out_free) state_next = iorb_pkg::ST_IDLE;
      end
      iorb_pkg::ST_REJ: begin
        if (sts.out_free) state_next = iorb_pkg::ST_READ;
      end
      iorb_pkg::ST_READ: begin
        state_next = sts.rel_go ? iorb_pkg::ST_REL : iorb_pkg::ST_IDLE;
      end
      iorb_pkg::ST_REL: begin
        if (sts.out_free) state_next = iorb_pkg::ST_READ;
      end
      default: state_next = iorb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state)
      iorb_pkg::ST_IDLE: begin
        ctl.in_ready = 1'b1;
        ctl.load     = sts.in_valid && !sts.finished;
      end
      iorb_pkg::ST_CHECK: ctl.insert     = sts.ordered && sts.win_ok;
      iorb_pkg::ST_UNORD: ctl.emit_unord = sts.out_free;
      iorb_pkg::ST_REJ:   ctl.emit_rej   = sts.out_free;
      iorb_pkg::ST_READ:  ctl.rd         = sts.rel_go;
      iorb_pkg::ST_REL:   ctl.emit_rel   = sts.out_free;
      default: ctl = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/in_order_release_buffer.sv @@
// ----------------------------------------------------------------------------
// in_order_release_buffer
// Holds completed requests by position and releases them in order.
// ----------------------------------------------------------------------------
// Order: an item is checked in the cycle after it is taken; a reject or a
//   pass-through result is then registered at the output once it is free.
// Each released request takes a slot read, then an output; at most 16
//   results per item. A new item is taken only when the last one is done,
//   and results wait while the output is stalled.
// Reset: synchronous; all slots free, counters zero, ordered mode.
`default_nettype none

module in_order_release_buffer #(
  parameter int WINDOW_DEPTH = iorb_pkg::WINDOW_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [iorb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [iorb_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              opcode,
  input  logic [iorb_pkg::POS_W-1:0]        request_position,
  input  logic [iorb_pkg::STATUS_W-1:0]     request_status,
  input  logic [iorb_pkg::HANDLE_W-1:0]     request_handle,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [iorb_pkg::HANDLE_W-1:0]     out_handle,
  output logic [iorb_pkg::POS_W-1:0]        out_position,
  output logic [iorb_pkg::STATUS_W-1:0]     out_status,
  output logic                              last_of_run,
  output logic                              end_of_stream,
  output logic                              rejected,
  output logic [iorb_pkg::COUNT_W-1:0]      ok_total
);

  localparam int IW  = $clog2(WINDOW_DEPTH);
  localparam int NW  = $clog2(iorb_pkg::MAX_RESULTS + 1);
  localparam logic [NW-1:0] MAX_N = NW'(iorb_pkg::MAX_RESULTS);

  logic                            ordered_mode;
  logic [iorb_pkg::STATUS_W-1:0]   ok_status;

  logic                            op_r;
  logic [iorb_pkg::POS_W-1:0]      tpos_r;
  logic [iorb_pkg::STATUS_W-1:0]   st_r;
  logic [iorb_pkg::HANDLE_W-1:0]   hd_r;

  logic [iorb_pkg::POS_W-1:0]      rc;
  logic [iorb_pkg::POS_W-1:0]      rc_next;
  logic [iorb_pkg::POS_W-1:0]      highest;
  logic [iorb_pkg::COUNT_W-1:0]    ok_count;
  logic [iorb_pkg::COUNT_W-1:0]    ok_next;
  logic                            finished;
  logic [IW-1:0]                   head;
  logic [IW-1:0]                   head_inc;
  logic [NW-1:0]                   n;

  logic [iorb_pkg::POS_W-1:0]      off;
  logic [IW:0]                     slot_sum;
  logic [IW-1:0]                   slot;
  logic                            pos_gt;
  logic                            win_ok;
  logic                            rel_go;
  logic                            more_rej;
  logic                            more_rel;
  logic                            head_end;
  logic                            count_hit;
  logic [iorb_pkg::STATUS_W-1:0]   count_st;
  logic                            out_free;
  logic                            emit_any;

  logic [WINDOW_DEPTH-1:0]         slot_valid;
  logic [WINDOW_DEPTH-1:0]         slot_end;
  iorb_pkg::slot_data_t            rd_data;
  iorb_pkg::slot_wr_t              wr_data;

  iorb_pkg::sts_t                  sts;
  iorb_pkg::ctl_t                  ctl;

  assign off      = tpos_r + ~rc;
  assign slot_sum = {1'b0, head} + {1'b0, off[IW-1:0]};
  assign slot     = (slot_sum >= (IW+1)'(WINDOW_DEPTH)) ?
                    IW'(slot_sum - (IW+1)'(WINDOW_DEPTH)) : slot_sum[IW-1:0];
  assign win_ok   = (off < iorb_pkg::POS_W'(WINDOW_DEPTH)) && !slot_valid[slot];
  assign pos_gt   = tpos_r > highest;
  assign head_inc = (head == IW'(WINDOW_DEPTH - 1)) ? '0 : head + IW'(1);
  assign head_end = slot_end[head];
  assign rc_next  = rc + iorb_pkg::POS_W'(1);

  assign rel_go   = (n < MAX_N) && !finished && slot_valid[head];
  assign more_rej = ((n + NW'(1)) < MAX_N) && slot_valid[head];
  assign more_rel = ((n + NW'(1)) < MAX_N) && !head_end && slot_valid[head_inc];

  assign count_st  = ctl.emit_rel ? rd_data.status : st_r;
  assign count_hit = (count_st == ok_status) && (ok_count != '1) &&
                     ((ctl.emit_unord && op_r == iorb_pkg::OP_REQUEST) ||
                      (ctl.emit_rel && !head_end));
  assign ok_next   = ok_count + iorb_pkg::COUNT_W'(count_hit);

  assign out_free = !out_valid || !out_stall;
  assign emit_any = ctl.emit_unord || ctl.emit_rej || ctl.emit_rel;

  assign sts = '{in_valid: in_valid, finished: finished, ordered: ordered_mode,
                 win_ok: win_ok, out_free: out_free, rel_go: rel_go};

  assign in_stall = !ctl.in_ready;

  assign wr_data = '{is_end: (op_r == iorb_pkg::OP_END), status: st_r, handle: hd_r};

  iorb_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .ctl (ctl)
  );

  iorb_slots #(
    .DEPTH (WINDOW_DEPTH),
    .IW    (IW)
  ) u_slots (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (ctl.insert),
    .wr_idx     (slot),
    .wr_data    (wr_data),
    .clr_en     (ctl.emit_rel),
    .clr_idx    (head),
    .rd_en      (ctl.rd),
    .rd_idx     (head),
    .rd_data    (rd_data),
    .slot_valid (slot_valid),
    .slot_end   (slot_end)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ordered_mode <= 1'b1;
      ok_status    <= '0;
      rc           <= '0;
      highest      <= '0;
      ok_count     <= '0;
      finished     <= 1'b0;
      head         <= IW'(1);
      n            <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          iorb_pkg::CFG_ORDERED_MODE: ordered_mode <= cfg_data[0];
          iorb_pkg::CFG_OK_STATUS:    ok_status    <= cfg_data;
          default: ;
        endcase
      end
      if (ctl.insert && op_r == iorb_pkg::OP_REQUEST && pos_gt) highest <= tpos_r;
      if (ctl.emit_unord) begin
        rc   <= rc_next;
        head <= head_inc;
        if (op_r == iorb_pkg::OP_REQUEST && pos_gt) highest <= tpos_r;
        if (op_r == iorb_pkg::OP_END) finished <= 1'b1;
      end
      if (ctl.emit_rel) begin
        rc   <= rc_next;
        head <= head_inc;
        if (head_end) finished <= 1'b1;
      end
      ok_count <= ok_next;
      if (ctl.load) begin
        n <= '0;
      end else if (ctl.emit_rej || ctl.emit_rel) begin
        n <= n + NW'(1);
      end
      if (emit_any) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_r   <= opcode;
      tpos_r <= (opcode == iorb_pkg::OP_END) ? highest + iorb_pkg::POS_W'(1)
                                             : request_position;
      st_r   <= (opcode == iorb_pkg::OP_END) ? '0 : request_status;
      hd_r   <= (opcode == iorb_pkg::OP_END) ? '0 : request_handle;
    end
    if (ctl.emit_unord) begin
      out_handle    <= hd_r;
      out_position  <= tpos_r;
      out_status    <= st_r;
      last_of_run   <= 1'b1;
      end_of_stream <= (op_r == iorb_pkg::OP_END);
      rejected      <= 1'b0;
      ok_total      <= ok_next;
    end else if (ctl.emit_rej) begin
      out_handle    <= hd_r;
      out_position  <= tpos_r;
      out_status    <= st_r;
      last_of_run   <= !more_rej;
      end_of_stream <= 1'b0;
      rejected      <= 1'b1;
      ok_total      <= ok_count;
    end else if (ctl.emit_rel) begin
      out_handle    <= head_end ? '0 : rd_data.handle;
      out_position  <= rc_next;
      out_status    <= head_end ? '0 : rd_data.status;
      last_of_run   <= !more_rel;
      end_of_stream <= head_end;
      rejected      <= 1'b0;
      ok_total      <= ok_next;
    end
  end

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    emit_any |-> out_free)
    else $error("result emitted while output register is occupied");

  a_result_bound: assert property (@(posedge clk) disable iff (rst)
    n <= MAX_N)
    else $error("too many results for one item");

  a_release_held: assert property (@(posedge clk) disable iff (rst)
    ctl.emit_rel |-> slot_valid[head])
    else $error("release from a free slot");

  a_no_insert_finished: assert property (@(posedge clk) disable iff (rst)
    ctl.insert |-> !finished)
    else $error("slot written after end of stream");

  a_release_advances: assert property (@(posedge clk) disable iff (rst)
    ctl.emit_rel |=> rc == $past(rc) + iorb_pkg::POS_W'(1))
    else $error("release count did not advance");

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives completed requests and end-of-stream items into the in-order release
// buffer, predicts every released, passed-through or rejected result from a
// model of the slot window held here, and checks each result field by field.
// Covers the window edges, duplicates, stale slots left by pass-through
// traffic, random ordered and unordered traffic, and the end of the stream.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int RANDOM_ITEMS  = 80;
  localparam int SETTLE_CYCLES = 24;
  localparam int QUIET_LIMIT   = 4000;

  typedef struct {
    bit                          op;
    bit [iorb_pkg::POS_W-1:0]    pos;
    bit [iorb_pkg::STATUS_W-1:0] status;
    bit [iorb_pkg::HANDLE_W-1:0] handle;
  } completion_t;

  typedef struct {
    bit [iorb_pkg::HANDLE_W-1:0] handle;
    bit [iorb_pkg::POS_W-1:0]    position;
    bit [iorb_pkg::STATUS_W-1:0] status;
    bit                          last;
    bit                          eos;
    bit                          rej;
    bit [iorb_pkg::COUNT_W-1:0]  ok_total;
  } release_t;

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [iorb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [iorb_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            opcode = iorb_pkg::OP_REQUEST;
  logic [iorb_pkg::POS_W-1:0]      request_position = '0;
  logic [iorb_pkg::STATUS_W-1:0]   request_status = '0;
  logic [iorb_pkg::HANDLE_W-1:0]   request_handle = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [iorb_pkg::HANDLE_W-1:0]   out_handle;
  logic [iorb_pkg::POS_W-1:0]      out_position;
  logic [iorb_pkg::STATUS_W-1:0]   out_status;
  logic                            last_of_run;
  logic                            end_of_stream;
  logic                            rejected;
  logic [iorb_pkg::COUNT_W-1:0]    ok_total;

  in_order_release_buffer dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .opcode           (opcode),
    .request_position (request_position),
    .request_status   (request_status),
    .request_handle   (request_handle),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_handle       (out_handle),
    .out_position     (out_position),
    .out_status       (out_status),
    .last_of_run      (last_of_run),
    .end_of_stream    (end_of_stream),
    .rejected         (rejected),
    .ok_total         (ok_total)
  );

  bit                          ordered_cfg = 1'b1;
  bit [iorb_pkg::STATUS_W-1:0] ok_code_cfg = '0;
  bit                          held        [iorb_pkg::WINDOW_DEPTH];
  bit                          held_end    [iorb_pkg::WINDOW_DEPTH];
  bit [iorb_pkg::STATUS_W-1:0] held_status [iorb_pkg::WINDOW_DEPTH];
  bit [iorb_pkg::HANDLE_W-1:0] held_handle [iorb_pkg::WINDOW_DEPTH];
  bit [iorb_pkg::POS_W-1:0]    released_pos = '0;
  bit [iorb_pkg::POS_W-1:0]    highest_pos  = '0;
  bit [iorb_pkg::COUNT_W-1:0]  ok_units     = '0;
  bit                          stream_done  = 1'b0;

  release_t awaited[$];
  int       fail_count  = 0;
  int       burst_left  = 0;
  bit       valid_up    = 1'b0;
  int       quiet_cycles = 0;
  int       stall_mode  = 0;
  int       stall_left  = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int slot_of(bit [iorb_pkg::POS_W-1:0] p);
    return int'(p % iorb_pkg::WINDOW_DEPTH);
  endfunction

  function automatic bit fits_window(bit [iorb_pkg::POS_W-1:0] p);
    bit [iorb_pkg::POS_W-1:0] off;
    off = p - (released_pos + 1);
    return off < iorb_pkg::WINDOW_DEPTH && !held[slot_of(p)];
  endfunction

  function automatic bit any_held();
    foreach (held[i]) if (held[i]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void count_ok(bit [iorb_pkg::STATUS_W-1:0] s);
    if (s == ok_code_cfg && ok_units != '1) ok_units++;
  endfunction

  function automatic void push_release(bit [iorb_pkg::HANDLE_W-1:0] h,
                                       bit [iorb_pkg::POS_W-1:0] p,
                                       bit [iorb_pkg::STATUS_W-1:0] s,
                                       bit eos, bit rej);
    release_t r;
    r.handle   = h;
    r.position = p;
    r.status   = s;
    r.last     = 1'b0;
    r.eos      = eos;
    r.rej      = rej;
    r.ok_total = ok_units;
    awaited.push_back(r);
  endfunction

  function automatic void predict_releases(completion_t c);
    int                       base_n;
    int                       s;
    bit [iorb_pkg::POS_W-1:0] marker;
    bit [iorb_pkg::POS_W-1:0] nxt;
    base_n = awaited.size();
    if (stream_done) return;
    if (!ordered_cfg) begin
      released_pos++;
      if (c.op == iorb_pkg::OP_REQUEST) begin
        if (c.pos > highest_pos) highest_pos = c.pos;
        count_ok(c.status);
        push_release(c.handle, c.pos, c.status, 1'b0, 1'b0);
      end else begin
        stream_done = 1'b1;
        push_release('0, highest_pos + 1, '0, 1'b1, 1'b0);
      end
    end else begin
      if (c.op == iorb_pkg::OP_REQUEST) begin
        if (!fits_window(c.pos)) begin
          push_release(c.handle, c.pos, c.status, 1'b0, 1'b1);
        end else begin
          s = slot_of(c.pos);
          held[s]        = 1'b1;
          held_end[s]    = 1'b0;
          held_status[s] = c.status;
          held_handle[s] = c.handle;
          if (c.pos > highest_pos) highest_pos = c.pos;
        end
      end else begin
        marker = highest_pos + 1;
        if (!fits_window(marker)) begin
          push_release('0, marker, '0, 1'b0, 1'b1);
        end else begin
          s = slot_of(marker);
          held[s]        = 1'b1;
          held_end[s]    = 1'b1;
          held_status[s] = '0;
          held_handle[s] = '0;
        end
      end
      while (awaited.size() - base_n < iorb_pkg::MAX_RESULTS && !stream_done) begin
        nxt = released_pos + 1;
        s = slot_of(nxt);
        if (!held[s]) break;
        held[s] = 1'b0;
        released_pos = nxt;
        if (held_end[s]) begin
          held_end[s] = 1'b0;
          stream_done = 1'b1;
          push_release('0, nxt, '0, 1'b1, 1'b0);
        end else begin
          count_ok(held_status[s]);
          push_release(held_handle[s], nxt, held_status[s], 1'b0, 1'b0);
        end
      end
    end
    if (awaited.size() > base_n) awaited[awaited.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(string field, logic [31:0] got, bit [31:0] want);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    release_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited.size() == 0) begin
        $error("result with none expected: position 0x%0h", out_position);
        fail_count++;
      end else begin
        want = awaited.pop_front();
        check_field("out_handle", 32'(out_handle), 32'(want.handle));
        check_field("out_position", out_position, want.position);
        check_field("out_status", 32'(out_status), 32'(want.status));
        check_field("last_of_run", 32'(last_of_run), 32'(want.last));
        check_field("end_of_stream", 32'(end_of_stream), 32'(want.eos));
        check_field("rejected", 32'(rejected), 32'(want.rej));
        check_field("ok_total", ok_total, want.ok_total);
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 96);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      2: out_stall <= (stall_left % 4) != 0;
      default: out_stall <= $urandom_range(0, 3) == 0;
    endcase
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic send_item(completion_t c, bit more);
    int gap;
    gap = 0;
    if (burst_left == 0) gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    if (gap > 0 && valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
    if (gap == 0 && !valid_up) gap = 1;
    repeat (gap) @(posedge clk);
    if (burst_left == 0)
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
    in_valid         <= 1'b1;
    valid_up         = 1'b1;
    opcode           <= c.op;
    request_position <= c.pos;
    request_status   <= c.status;
    request_handle   <= c.handle;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_releases(c);
    burst_left--;
    if (!more) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  task automatic write_reg(logic [iorb_pkg::CFG_IDX_W-1:0] idx,
                           logic [iorb_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == iorb_pkg::CFG_ORDERED_MODE) ordered_cfg = val[0];
    else ok_code_cfg = val;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic shuffle_positions(ref bit [iorb_pkg::POS_W-1:0] list[$]);
    int                       k;
    bit [iorb_pkg::POS_W-1:0] t;
    for (int j = list.size() - 1; j > 0; j--) begin
      k = $urandom_range(0, j);
      t = list[j];
      list[j] = list[k];
      list[k] = t;
    end
  endtask

  task automatic test_window_limits();
    completion_t c;
    c = '{iorb_pkg::OP_REQUEST, 32'd3, 8'h00, 16'h0003};
    send_item(c, 1'b1);
    c = '{iorb_pkg::OP_REQUEST, 32'd1, 8'h00, 16'h0001};
    send_item(c, 1'b1);
    c = '{iorb_pkg::OP_REQUEST, 32'd1, 8'h11, 16'h0101};
    send_item(c, 1'b1);
    c = '{iorb_pkg::OP_REQUEST, 32'd18, 8'h00, 16'h0018};
    send_item(c, 1'b1);
    c = '{iorb_pkg::OP_REQUEST, 32'd17, 8'h00, 16'h0017};
    send_item(c, 1'b1);
    c = '{iorb_pkg::OP_REQUEST, 32'd17, 8'h22, 16'h1717};
    send_item(c, 1'b1);
    c = '{iorb_pkg::OP_REQUEST, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF};
    send_item(c, 1'b1);
    c = '{iorb_pkg::OP_REQUEST, 32'd0, 8'h00, 16'h0000};
    send_item(c, 1'b1);
    c = '{iorb_pkg::OP_END, 32'd0, 8'h00, 16'h0000};
    send_item(c, 1'b1);
    // fill the window from the top so that one item releases sixteen
    for (int p = 16; p >= 4; p--) begin
      c = '{iorb_pkg::OP_REQUEST, 32'(p), p[0] ? 8'h00 : 8'($urandom), 16'($urandom)};
      send_item(c, 1'b1);
    end
    c = '{iorb_pkg::OP_REQUEST, 32'd2, 8'h00, 16'hBEEF};
    send_item(c, 1'b0);
    wait_idle();
  endtask

  task automatic test_pass_through();
    completion_t c;
    // leave a gap behind so that pass-through traffic makes the slot stale
    c = '{iorb_pkg::OP_REQUEST, released_pos + 3, 8'hFF, 16'hA5A5};
    send_item(c, 1'b0);
    wait_idle();
    write_reg(iorb_pkg::CFG_ORDERED_MODE, 8'd0);
    write_reg(iorb_pkg::CFG_OK_STATUS, 8'hFF);
    c = '{iorb_pkg::OP_REQUEST, released_pos + 7, 8'hFF, 16'h1234};
    send_item(c, 1'b1);
    c = '{iorb_pkg::OP_REQUEST, 32'd1, 8'h00, 16'hFFFF};
    send_item(c, 1'b0);
    wait_idle();
    write_reg(iorb_pkg::CFG_ORDERED_MODE, 8'd1);
    c = '{iorb_pkg::OP_REQUEST, released_pos + 4, 8'hFF, 16'h0F0F};
    send_item(c, 1'b0);
    wait_idle();
  endtask

  task automatic run_ordered_burst(int count);
    completion_t              c;
    bit [iorb_pkg::POS_W-1:0] plan[$];
    int                       k;
    for (int i = 0; i < count; i++) begin
      if (plan.size() == 0) begin
        k = ($urandom_range(0, 4) == 0) ? iorb_pkg::WINDOW_DEPTH : $urandom_range(1, 8);
        for (int j = 1; j <= k; j++) plan.push_back(released_pos + j);
        shuffle_positions(plan);
      end
      c.op     = iorb_pkg::OP_REQUEST;
      c.pos    = $urandom;
      c.status = $urandom_range(0, 1) ? ok_code_cfg : 8'($urandom);
      c.handle = 16'($urandom);
      case ($urandom_range(0, 19))
        0: ;
        1: c.pos = released_pos - $urandom_range(0, 40);
        2: c.pos = released_pos + $urandom_range(1, 20);
        3: if (!fits_window(highest_pos + 1)) c.op = iorb_pkg::OP_END;
        default: c.pos = plan.pop_front();
      endcase
      send_item(c, i != count - 1);
    end
  endtask

  task automatic run_unordered_burst(int count);
    completion_t c;
    for (int i = 0; i < count; i++) begin
      c.op     = iorb_pkg::OP_REQUEST;
      c.status = $urandom_range(0, 1) ? ok_code_cfg : 8'($urandom);
      c.handle = 16'($urandom);
      if ($urandom_range(0, 4) == 0) c.pos = $urandom_range(0, released_pos);
      else c.pos = released_pos + $urandom_range(1, 4);
      send_item(c, i != count - 1);
    end
  endtask

  task automatic test_random_traffic();
    int                          sent;
    int                          n;
    bit [iorb_pkg::STATUS_W-1:0] ok_code;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      n = $urandom_range(12, 28);
      case ($urandom_range(0, 3))
        0: ok_code = 8'h00;
        1: ok_code = 8'hFF;
        default: ok_code = 8'($urandom);
      endcase
      write_reg(iorb_pkg::CFG_OK_STATUS, ok_code);
      write_reg(iorb_pkg::CFG_ORDERED_MODE, ($urandom_range(0, 3) != 0) ? 8'd1 : 8'd0);
      if (ordered_cfg) run_ordered_burst(n);
      else run_unordered_burst(n);
      wait_idle();
      sent += n;
    end
  endtask

  task automatic test_end_of_stream();
    completion_t              c;
    bit [iorb_pkg::POS_W-1:0] fill[$];
    bit [iorb_pkg::POS_W-1:0] span;
    write_reg(iorb_pkg::CFG_ORDERED_MODE, 8'd1);
    c = '{iorb_pkg::OP_REQUEST, 32'd0, ok_code_cfg, 16'h0000};
    // drain held and stale slots
    while (any_held()) begin
      c.pos    = released_pos + 1;
      c.handle = 16'($urandom);
      send_item(c, 1'b0);
    end
    if ($signed(highest_pos - released_pos) < 0) begin
      c.pos = released_pos + 1;
      send_item(c, 1'b0);
    end
    span = highest_pos - released_pos;
    if (span < iorb_pkg::WINDOW_DEPTH && $urandom_range(0, 2) != 0) begin
      if (span == 0) begin
        c.pos = released_pos + 2;
        send_item(c, 1'b1);
      end
      c.op = iorb_pkg::OP_END;
      send_item(c, 1'b1);
      c.op = iorb_pkg::OP_REQUEST;
      span = highest_pos - released_pos;
      for (int j = 1; j <= int'(span); j++)
        if (!held[slot_of(released_pos + j)]) fill.push_back(released_pos + j);
      shuffle_positions(fill);
      foreach (fill[i]) begin
        c.pos    = fill[i];
        c.status = $urandom_range(0, 1) ? ok_code_cfg : 8'($urandom);
        c.handle = 16'($urandom);
        send_item(c, i != fill.size() - 1);
      end
    end else begin
      wait_idle();
      write_reg(iorb_pkg::CFG_ORDERED_MODE, 8'd0);
      c.op = iorb_pkg::OP_END;
      send_item(c, 1'b0);
    end
    wait_idle();
    // drop everything once the stream has ended
    for (int j = 0; j < 4; j++) begin
      c.op     = j[0] ? iorb_pkg::OP_END : iorb_pkg::OP_REQUEST;
      c.pos    = released_pos + $urandom_range(1, 3);
      c.status = 8'($urandom);
      c.handle = 16'($urandom);
      send_item(c, j != 3);
    end
    wait_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_window_limits();
    test_pass_through();
    test_random_traffic();
    test_end_of_stream();
    if (awaited.size() != 0) begin
      $error("%0d results never arrived", awaited.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/iorb_pkg.sv
hw/rtl/iorb_slots.sv
hw/rtl/iorb_ctrl.sv
hw/rtl/in_order_release_buffer.sv
verif/tb_top.sv
